>>> rtl/iortt_pkg.sv
// ----------------------------------------------------------------------------
// iortt_pkg
// shared types and constants for the i/o region translation table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package iortt_pkg;

   // fixed widths of the item fields
   localparam int FIELD_WIDTH = 32;
   localparam int INDEX_WIDTH = 5;

   typedef enum logic [1:0] {
      OP_INSERT    = 2'd0,
      OP_TRANSLATE = 2'd1,
      OP_REMOVE    = 2'd2,
      OP_LOOKUP    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_NOT_FOUND = 2'd2
   } status_type;

   // control part of the item token walking the cell chain
   typedef struct packed {
      logic   valid;
      op_type op;
      logic   found;
   } tok_ctrl_type;

endpackage

`default_nettype wire

>>> rtl/iortt_cell.sv
// ----------------------------------------------------------------------------
// iortt_cell
// one table slot; checks the passing item, updates the slot, forwards the item
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module iortt_cell #(
   parameter int ADDR_WIDTH = 32,
   parameter int CELL_INDEX = 0
) (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire  iortt_pkg::tok_ctrl_type          in_ctrl,
   input  wire  [ADDR_WIDTH-1:0]                  in_phys_address,
   input  wire  [ADDR_WIDTH-1:0]                  in_virt_base,
   input  wire  [iortt_pkg::FIELD_WIDTH-1:0]      in_map_handle,
   input  wire  [ADDR_WIDTH-1:0]                  in_region_size,
   input  wire  [iortt_pkg::FIELD_WIDTH-1:0]      in_trans,
   input  wire  [iortt_pkg::FIELD_WIDTH-1:0]      in_pbase,
   input  wire  [iortt_pkg::FIELD_WIDTH-1:0]      in_size,
   input  wire  [iortt_pkg::FIELD_WIDTH-1:0]      in_handle,
   input  wire  [iortt_pkg::INDEX_WIDTH-1:0]      in_slot,
   output iortt_pkg::tok_ctrl_type                out_ctrl,
   output logic [ADDR_WIDTH-1:0]                  out_phys_address,
   output logic [ADDR_WIDTH-1:0]                  out_virt_base,
   output logic [iortt_pkg::FIELD_WIDTH-1:0]      out_map_handle,
   output logic [ADDR_WIDTH-1:0]                  out_region_size,
   output logic [iortt_pkg::FIELD_WIDTH-1:0]      out_trans,
   output logic [iortt_pkg::FIELD_WIDTH-1:0]      out_pbase,
   output logic [iortt_pkg::FIELD_WIDTH-1:0]      out_size,
   output logic [iortt_pkg::FIELD_WIDTH-1:0]      out_handle,
   output logic [iortt_pkg::INDEX_WIDTH-1:0]      out_slot
);

   localparam int FW = iortt_pkg::FIELD_WIDTH;
   localparam logic [iortt_pkg::INDEX_WIDTH-1:0] CELL_SLOT =
      CELL_INDEX[iortt_pkg::INDEX_WIDTH-1:0];

   // slot contents
   logic [FW-1:0]         handle_ff, handle_in;
   logic [ADDR_WIDTH-1:0] vbase_ff, vbase_in;
   logic [ADDR_WIDTH-1:0] pbase_ff, pbase_in;
   logic [ADDR_WIDTH-1:0] size_ff, size_in;

   // token registers
   iortt_pkg::tok_ctrl_type ctrl_ff, ctrl_in;
   logic [ADDR_WIDTH-1:0] paddr_ff, vaddr_ff, rsize_ff;
   logic [FW-1:0]         mhandle_ff;
   logic [FW-1:0]         trans_ff, trans_in;
   logic [FW-1:0]         rpbase_ff, rpbase_in;
   logic [FW-1:0]         rsz_ff, rsz_in;
   logic [FW-1:0]         rhandle_ff, rhandle_in;
   logic [iortt_pkg::INDEX_WIDTH-1:0] slot_ff, slot_in;

   logic [ADDR_WIDTH-1:0] offset;
   logic                  in_range;
   logic                  match;
   logic                  take;

   always_comb begin
      offset   = in_phys_address - pbase_ff;
      in_range = (in_phys_address >= pbase_ff) && (offset < size_ff);
      case (in_ctrl.op)
         iortt_pkg::OP_INSERT:    match = (handle_ff == '0);
         iortt_pkg::OP_TRANSLATE: match = in_range;
         iortt_pkg::OP_REMOVE:    match = in_range;
         iortt_pkg::OP_LOOKUP:    match = (handle_ff != '0) && (vbase_ff == in_virt_base);
         default:                 match = 1'b0;
      endcase
      take = in_ctrl.valid && !in_ctrl.found && match;
   end

   // slot update on a hit
   always_comb begin
      handle_in = handle_ff;
      vbase_in  = vbase_ff;
      pbase_in  = pbase_ff;
      size_in   = size_ff;
      if (take) begin
         case (in_ctrl.op)
            iortt_pkg::OP_INSERT: begin
               handle_in = in_map_handle;
               vbase_in  = in_virt_base;
               pbase_in  = in_phys_address;
               size_in   = in_region_size;
            end
            iortt_pkg::OP_REMOVE: begin
               handle_in = '0;
               vbase_in  = '0;
               pbase_in  = '0;
               size_in   = '0;
            end
            default: begin
            end
         endcase
      end
   end

   // result fields of the passing item
   always_comb begin
      ctrl_in       = in_ctrl;
      ctrl_in.found = in_ctrl.found || take;
      trans_in      = in_trans;
      rpbase_in     = in_pbase;
      rsz_in        = in_size;
      rhandle_in    = in_handle;
      slot_in       = in_slot;
      if (take) begin
         slot_in = CELL_SLOT;
         if (in_ctrl.op == iortt_pkg::OP_INSERT) begin
            trans_in   = '0;
            rpbase_in  = '0;
            rsz_in     = '0;
            rhandle_in = '0;
         end else begin
            rpbase_in  = FW'(pbase_ff);
            rsz_in     = FW'(size_ff);
            rhandle_in = handle_ff;
            trans_in   = (in_ctrl.op == iortt_pkg::OP_TRANSLATE) ?
                         FW'(ADDR_WIDTH'(vbase_ff + offset)) : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         handle_ff <= '0;
         vbase_ff  <= '0;
         pbase_ff  <= '0;
         size_ff   <= '0;
         ctrl_ff   <= '0;
      end else begin
         handle_ff <= handle_in;
         vbase_ff  <= vbase_in;
         pbase_ff  <= pbase_in;
         size_ff   <= size_in;
         ctrl_ff   <= ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      paddr_ff   <= in_phys_address;
      vaddr_ff   <= in_virt_base;
      mhandle_ff <= in_map_handle;
      rsize_ff   <= in_region_size;
      trans_ff   <= trans_in;
      rpbase_ff  <= rpbase_in;
      rsz_ff     <= rsz_in;
      rhandle_ff <= rhandle_in;
      slot_ff    <= slot_in;
   end

   assign out_ctrl         = ctrl_ff;
   assign out_phys_address = paddr_ff;
   assign out_virt_base    = vaddr_ff;
   assign out_map_handle   = mhandle_ff;
   assign out_region_size  = rsize_ff;
   assign out_trans        = trans_ff;
   assign out_pbase        = rpbase_ff;
   assign out_size         = rsz_ff;
   assign out_handle       = rhandle_ff;
   assign out_slot         = slot_ff;

endmodule

`default_nettype wire

>>> rtl/io_region_translation_table_core.sv
// ----------------------------------------------------------------------------
// io_region_translation_table_core
// region table built as a chain of slot cells; one item walks the chain
// ----------------------------------------------------------------------------
// the item is registered in each slot cell in turn; rsp_valid is registered from
// the chain output. one item at a time: a new item is taken the cycle after the
//    result is taken; the item visits one slot cell a cycle
// reset: synchronous, clears every slot and all control state
`timescale 1ns / 1ps
`default_nettype none

module io_region_translation_table_core #(
   parameter int SLOTS      = 20,
   parameter int ADDR_WIDTH = 32
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [1:0]  req_operation,
   input  wire  [31:0] req_phys_address,
   input  wire  [31:0] req_virt_base,
   input  wire  [31:0] req_map_handle,
   input  wire  [31:0] req_region_size,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_translated_address,
   output logic [31:0] rsp_phys_base_out,
   output logic [31:0] rsp_size_out,
   output logic [31:0] rsp_handle_out,
   output logic [4:0]  rsp_slot_index
);

   localparam int FW = iortt_pkg::FIELD_WIDTH;
   localparam int IW = iortt_pkg::INDEX_WIDTH;

   // chain taps: tap k feeds cell k, tap SLOTS is the chain output
   iortt_pkg::tok_ctrl_type ctrl_tap [0:SLOTS];
   logic [FW-1:0]           trans_tap [0:SLOTS];
   logic [FW-1:0]           pbase_tap [0:SLOTS];
   logic [FW-1:0]           size_tap [0:SLOTS];
   logic [FW-1:0]           handle_tap [0:SLOTS];
   logic [IW-1:0]           slot_tap [0:SLOTS];

   // request fields only travel as far as the last cell
   logic [ADDR_WIDTH-1:0]   paddr_tap [0:SLOTS-1];
   logic [ADDR_WIDTH-1:0]   vbase_tap [0:SLOTS-1];
   logic [FW-1:0]           mhandle_tap [0:SLOTS-1];
   logic [ADDR_WIDTH-1:0]   rsize_tap [0:SLOTS-1];

   // busy from accept until the result is taken
   logic busy_ff, busy_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [1:0]    status_ff, status_in;
   logic [FW-1:0] trans_ff, pbase_ff, size_ff, handle_ff;
   logic [IW-1:0] slot_ff;
   logic          req_take;
   logic          rsp_take;
   logic          chain_done;

   assign req_take   = req_valid && !busy_ff;
   assign rsp_take   = rsp_valid_ff && !rsp_stall;
   assign chain_done = ctrl_tap[SLOTS].valid;

   // item enters cell 0 straight from the ports, with empty result fields
   assign ctrl_tap[0]    = '{valid: req_take,
                             op:    iortt_pkg::op_type'(req_operation),
                             found: 1'b0};
   assign trans_tap[0]   = '0;
   assign pbase_tap[0]   = '0;
   assign size_tap[0]    = '0;
   assign handle_tap[0]  = '0;
   assign slot_tap[0]    = '0;
   assign paddr_tap[0]   = ADDR_WIDTH'(req_phys_address);
   assign vbase_tap[0]   = ADDR_WIDTH'(req_virt_base);
   assign mhandle_tap[0] = req_map_handle;
   assign rsize_tap[0]   = ADDR_WIDTH'(req_region_size);

   // one cell per slot, lowest slot first so the first hit wins
   genvar k;
   generate
      for (k = 0; k < SLOTS; k++) begin : g_cell
         if (k < SLOTS - 1) begin : g_mid
            iortt_cell #(
               .ADDR_WIDTH (ADDR_WIDTH),
               .CELL_INDEX (k)
            ) u_cell (
               .clock            (clock),
               .reset            (reset),
               .in_ctrl          (ctrl_tap[k]),
               .in_phys_address  (paddr_tap[k]),
               .in_virt_base     (vbase_tap[k]),
               .in_map_handle    (mhandle_tap[k]),
               .in_region_size   (rsize_tap[k]),
               .in_trans         (trans_tap[k]),
               .in_pbase         (pbase_tap[k]),
               .in_size          (size_tap[k]),
               .in_handle        (handle_tap[k]),
               .in_slot          (slot_tap[k]),
               .out_ctrl         (ctrl_tap[k+1]),
               .out_phys_address (paddr_tap[k+1]),
               .out_virt_base    (vbase_tap[k+1]),
               .out_map_handle   (mhandle_tap[k+1]),
               .out_region_size  (rsize_tap[k+1]),
               .out_trans        (trans_tap[k+1]),
               .out_pbase        (pbase_tap[k+1]),
               .out_size         (size_tap[k+1]),
               .out_handle       (handle_tap[k+1]),
               .out_slot         (slot_tap[k+1])
            );
         end else begin : g_last
            // last cell: request fields end here
            iortt_cell #(
               .ADDR_WIDTH (ADDR_WIDTH),
               .CELL_INDEX (k)
            ) u_cell (
               .clock            (clock),
               .reset            (reset),
               .in_ctrl          (ctrl_tap[k]),
               .in_phys_address  (paddr_tap[k]),
               .in_virt_base     (vbase_tap[k]),
               .in_map_handle    (mhandle_tap[k]),
               .in_region_size   (rsize_tap[k]),
               .in_trans         (trans_tap[k]),
               .in_pbase         (pbase_tap[k]),
               .in_size          (size_tap[k]),
               .in_handle        (handle_tap[k]),
               .in_slot          (slot_tap[k]),
               .out_ctrl         (ctrl_tap[k+1]),
               .out_phys_address (),
               .out_virt_base    (),
               .out_map_handle   (),
               .out_region_size  (),
               .out_trans        (trans_tap[k+1]),
               .out_pbase        (pbase_tap[k+1]),
               .out_size         (size_tap[k+1]),
               .out_handle       (handle_tap[k+1]),
               .out_slot         (slot_tap[k+1])
            );
         end
      end
   endgenerate

   // status from the chain output: a miss is full for insert, not found else
   always_comb begin
      if (ctrl_tap[SLOTS].found) begin
         status_in = iortt_pkg::ST_OK;
      end else if (ctrl_tap[SLOTS].op == iortt_pkg::OP_INSERT) begin
         status_in = iortt_pkg::ST_FULL;
      end else begin
         status_in = iortt_pkg::ST_NOT_FOUND;
      end
   end

   // control: busy and result valid
   always_comb begin
      busy_in      = busy_ff;
      rsp_valid_in = rsp_valid_ff;
      if (req_take) begin
         busy_in = 1'b1;
      end
      if (chain_done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_take) begin
         rsp_valid_in = 1'b0;
         busy_in      = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result register, loaded when the item leaves the last cell
   always_ff @(posedge clock) begin
      if (chain_done) begin
         status_ff <= status_in;
         trans_ff  <= trans_tap[SLOTS];
         pbase_ff  <= pbase_tap[SLOTS];
         size_ff   <= size_tap[SLOTS];
         handle_ff <= handle_tap[SLOTS];
         slot_ff   <= slot_tap[SLOTS];
      end
   end

   assign req_stall              = busy_ff;
   assign rsp_valid              = rsp_valid_ff;
   assign rsp_status             = status_ff;
   assign rsp_translated_address = trans_ff;
   assign rsp_phys_base_out      = pbase_ff;
   assign rsp_size_out           = size_ff;
   assign rsp_handle_out         = handle_ff;
   assign rsp_slot_index         = slot_ff;

endmodule

`default_nettype wire

>>> rtl/iortt_checker.sv
// ----------------------------------------------------------------------------
// iortt_checker
// port-level checks for the region translation table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module iortt_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_valid,
   input wire        req_stall,
   input wire        rsp_valid,
   input wire        rsp_stall,
   input wire [1:0]  rsp_status,
   input wire [31:0] rsp_translated_address,
   input wire [31:0] rsp_phys_base_out,
   input wire [31:0] rsp_size_out,
   input wire [31:0] rsp_handle_out,
   input wire [4:0]  rsp_slot_index
);

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // one item in flight: taking an item closes the input
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second item taken while one is in flight");

   // a pending result keeps the input closed
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input open while a result is pending");

   // a failed operation reports nothing but its status
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != iortt_pkg::ST_OK) |->
         (rsp_translated_address == '0) && (rsp_phys_base_out == '0) &&
         (rsp_size_out == '0) && (rsp_handle_out == '0) && (rsp_slot_index == '0))
      else $error("miss carries nonzero result fields");

endmodule

bind io_region_translation_table_core iortt_checker u_iortt_checker (.*);

`default_nettype wire

>>> verif/tb_io_region_translation_table_core.sv
// ----------------------------------------------------------------------------
// tb_io_region_translation_table_core
// self-checking bench for the region translation table: a short directed
// table, then random insert/translate/remove/lookup traffic in grow and
// shrink phases; every result is checked against a typed row's want or a shadow table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_io_region_translation_table_core;

   localparam int SLOTS        = 20;
   localparam int RANDOM_ITEMS = 680;
   localparam int PHASE_LEN    = 60;
   // long receiver hold-off so the block stalls its input
   localparam int HOLD_AT      = 40;
   localparam int HOLD_CYCLES  = 300;

   // one result item, field by field
   typedef struct packed {
      iortt_pkg::status_type status;
      logic [31:0]           trans_addr;
      logic [31:0]           phys_base;
      logic [31:0]           region_len;
      logic [31:0]           handle;
      logic [4:0]            slot;
   } region_result_type;

   // one row of the directed table; want is used only when typed is set
   typedef struct {
      iortt_pkg::op_type  op;
      logic [31:0]        phys;
      logic [31:0]        virt;
      logic [31:0]        handle;
      logic [31:0]        len;
      int unsigned        reps;
      bit                 typed;
      region_result_type  want;
   } stim_row_type;

   localparam region_result_type NOT_FOUND_RESULT =
      '{status: iortt_pkg::ST_NOT_FOUND, default: '0};
   localparam region_result_type FULL_RESULT =
      '{status: iortt_pkg::ST_FULL, default: '0};

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_operation;
   logic [31:0] req_phys_address;
   logic [31:0] req_virt_base;
   logic [31:0] req_map_handle;
   logic [31:0] req_region_size;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_translated_address;
   logic [31:0] rsp_phys_base_out;
   logic [31:0] rsp_size_out;
   logic [31:0] rsp_handle_out;
   logic [4:0]  rsp_slot_index;

   // shadow copy of the region table, cleared like the block at reset
   logic [31:0] tbl_handle [SLOTS] = '{default: '0};
   logic [31:0] tbl_virt   [SLOTS] = '{default: '0};
   logic [31:0] tbl_phys   [SLOTS] = '{default: '0};
   logic [31:0] tbl_len    [SLOTS] = '{default: '0};

   region_result_type pending_results [$];
   stim_row_type      stim_rows [$];
   int unsigned       mismatches = 0;
   // set during phases with no idling on either side
   bit                quiet_phase = 1'b0;

   io_region_translation_table_core #(
      .SLOTS      (SLOTS),
      .ADDR_WIDTH (32)
   ) u_top (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_operation          (req_operation),
      .req_phys_address       (req_phys_address),
      .req_virt_base          (req_virt_base),
      .req_map_handle         (req_map_handle),
      .req_region_size        (req_region_size),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_status             (rsp_status),
      .rsp_translated_address (rsp_translated_address),
      .rsp_phys_base_out      (rsp_phys_base_out),
      .rsp_size_out           (rsp_size_out),
      .rsp_handle_out         (rsp_handle_out),
      .rsp_slot_index         (rsp_slot_index)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // apply one item to the shadow table and return the result it causes
   function automatic region_result_type apply_region_op(input iortt_pkg::op_type op,
                                                         input logic [31:0] pa, vb, hd, len);
      region_result_type res;
      int hit;
      res = NOT_FOUND_RESULT;
      hit = -1;
      case (op)
         iortt_pkg::OP_INSERT: begin
            // lowest slot with a zero handle is free
            for (int k = 0; k < SLOTS; k++)
               if (hit < 0 && tbl_handle[k] == '0) hit = k;
            if (hit < 0) begin
               res.status = iortt_pkg::ST_FULL;
            end else begin
               tbl_handle[hit] = hd;
               tbl_virt[hit]   = vb;
               tbl_phys[hit]   = pa;
               tbl_len[hit]    = len;
               res.status      = iortt_pkg::ST_OK;
               res.slot        = 5'(hit);
            end
         end
         iortt_pkg::OP_LOOKUP: begin
            // only occupied slots take part
            for (int k = 0; k < SLOTS; k++)
               if (hit < 0 && tbl_handle[k] != '0 && tbl_virt[k] == vb) hit = k;
         end
         default: begin
            // range test on every slot, free or not, no wraparound
            for (int k = 0; k < SLOTS; k++)
               if (hit < 0 && pa >= tbl_phys[k] && (pa - tbl_phys[k]) < tbl_len[k]) hit = k;
         end
      endcase
      if (op != iortt_pkg::OP_INSERT && hit >= 0) begin
         res.status     = iortt_pkg::ST_OK;
         res.slot       = 5'(hit);
         res.phys_base  = tbl_phys[hit];
         res.region_len = tbl_len[hit];
         res.handle     = tbl_handle[hit];
         if (op == iortt_pkg::OP_TRANSLATE)
            res.trans_addr = tbl_virt[hit] + (pa - tbl_phys[hit]);
         if (op == iortt_pkg::OP_REMOVE) begin
            tbl_handle[hit] = '0;
            tbl_virt[hit]   = '0;
            tbl_phys[hit]   = '0;
            tbl_len[hit]    = '0;
         end
      end
      return res;
   endfunction

   function automatic void add_row(input iortt_pkg::op_type op,
                                   input logic [31:0] pa, vb, hd, len,
                                   input int unsigned reps, input bit typed,
                                   input region_result_type want);
      stim_row_type row;
      row.op     = op;
      row.phys   = pa;
      row.virt   = vb;
      row.handle = hd;
      row.len    = len;
      row.reps   = reps;
      row.typed  = typed;
      row.want   = want;
      stim_rows.push_back(row);
   endfunction

   // random item: mostly hits on live regions, the rest plain noise
   task automatic draw_request(input bit grow, output iortt_pkg::op_type op,
                               output logic [31:0] pa, vb, hd, len);
      int unsigned roll;
      int unsigned pick;
      int unsigned k;
      pa   = $urandom;
      vb   = $urandom;
      hd   = $urandom;
      len  = $urandom;
      roll = $urandom_range(0, 99);
      pick = $urandom_range(0, 9);
      k    = $urandom_range(0, SLOTS - 1);
      if (grow) begin
         if (roll < 45) op = iortt_pkg::OP_INSERT;
         else if (roll < 75) op = iortt_pkg::OP_TRANSLATE;
         else if (roll < 85) op = iortt_pkg::OP_REMOVE;
         else op = iortt_pkg::OP_LOOKUP;
      end else begin
         if (roll < 15) op = iortt_pkg::OP_INSERT;
         else if (roll < 45) op = iortt_pkg::OP_TRANSLATE;
         else if (roll < 80) op = iortt_pkg::OP_REMOVE;
         else op = iortt_pkg::OP_LOOKUP;
      end
      case (op)
         iortt_pkg::OP_INSERT: begin
            if (pick < 7) len = $urandom_range(1, 4096);
            else if (pick == 7) len = '0;
            // small pool of virtual bases gives duplicate lookups
            if (pick < 5) vb = 32'h1000_0000 | ($urandom_range(0, 7) << 12);
            // overlap with a region already present
            if (pick == 9) pa = tbl_phys[k] + $urandom_range(0, 255);
            if ($urandom_range(0, 15) == 0) hd = '0;
         end
         iortt_pkg::OP_TRANSLATE, iortt_pkg::OP_REMOVE: begin
            if (pick < 8 && tbl_len[k] != '0) pa = tbl_phys[k] + ($urandom % tbl_len[k]);
         end
         default: begin
            if (pick < 8) vb = tbl_virt[k];
         end
      endcase
   endtask

   // offer one item after a random gap, none in a quiet phase, and return at the edge it is taken
   task automatic offer_request(input iortt_pkg::op_type op,
                                input logic [31:0] pa, vb, hd, len);
      int unsigned gap;
      gap = quiet_phase ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_operation    <= op;
      req_phys_address <= pa;
      req_virt_base    <= vb;
      req_map_handle   <= hd;
      req_region_size  <= len;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic compare_field(input string field, input logic [31:0] want, got);
      if (want !== got) begin
         $display("%0t: %s expected %h actual %h", $time, field, want, got);
         mismatches++;
      end
   endtask

   // sender side: directed table, random traffic, then drain and verdict
   initial begin : req_side
      region_result_type predicted;
      iortt_pkg::op_type op;
      logic [31:0]       pa, vb, hd, len;
      int unsigned       phase;

      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_operation    <= iortt_pkg::OP_INSERT;
      req_phys_address <= '0;
      req_virt_base    <= '0;
      req_map_handle   <= '0;
      req_region_size  <= '0;

      // empty table: nothing matches, free slots never match a lookup
      add_row(iortt_pkg::OP_TRANSLATE, 32'h0, 32'h0, 32'h0, 32'h0, 1, 1'b1,
              NOT_FOUND_RESULT);
      add_row(iortt_pkg::OP_LOOKUP, 32'h0, 32'h0, 32'h0, 32'h0, 1, 1'b1,
              NOT_FOUND_RESULT);
      add_row(iortt_pkg::OP_REMOVE, 32'h0, 32'h0, 32'h0, 32'h0, 1, 1'b1,
              NOT_FOUND_RESULT);
      add_row(iortt_pkg::OP_INSERT, 32'h1000, 32'h8000_0000, 32'h1, 32'h100, 1, 1'b1,
              '{status: iortt_pkg::ST_OK, slot: 5'd0, default: '0});
      // last byte in range, one past the end, one below the base
      add_row(iortt_pkg::OP_TRANSLATE, 32'h10ff, 32'h0, 32'h0, 32'h0, 1, 1'b0,
              NOT_FOUND_RESULT);
      add_row(iortt_pkg::OP_TRANSLATE, 32'h1100, 32'h0, 32'h0, 32'h0, 1, 1'b0,
              NOT_FOUND_RESULT);
      add_row(iortt_pkg::OP_TRANSLATE, 32'h0fff, 32'h0, 32'h0, 32'h0, 1, 1'b0,
              NOT_FOUND_RESULT);
      // zero handle keeps the slot free, still range-matched, not looked up
      add_row(iortt_pkg::OP_INSERT, 32'h2000, 32'h1234, 32'h0, 32'h10, 1, 1'b1,
              '{status: iortt_pkg::ST_OK, slot: 5'd1, default: '0});
      add_row(iortt_pkg::OP_TRANSLATE, 32'h2008, 32'h0, 32'h0, 32'h0, 1, 1'b0,
              NOT_FOUND_RESULT);
      add_row(iortt_pkg::OP_LOOKUP, 32'h0, 32'h1234, 32'h0, 32'h0, 1, 1'b0,
              NOT_FOUND_RESULT);
      // all-ones fields overwrite the free slot; translate sum wraps
      add_row(iortt_pkg::OP_INSERT, 32'hffff_fff0, 32'hffff_ffff, 32'hffff_ffff,
              32'hffff_ffff, 1, 1'b1,
              '{status: iortt_pkg::ST_OK, slot: 5'd1, default: '0});
      add_row(iortt_pkg::OP_TRANSLATE, 32'hffff_ffff, 32'h0, 32'h0, 32'h0, 1, 1'b0,
              NOT_FOUND_RESULT);
      add_row(iortt_pkg::OP_TRANSLATE, 32'h5, 32'h0, 32'h0, 32'h0, 1, 1'b0,
              NOT_FOUND_RESULT);
      // zero size never matches a range but is found by virtual base
      add_row(iortt_pkg::OP_INSERT, 32'h3000, 32'h5000, 32'h5, 32'h0, 1, 1'b1,
              '{status: iortt_pkg::ST_OK, slot: 5'd2, default: '0});
      add_row(iortt_pkg::OP_TRANSLATE, 32'h3000, 32'h0, 32'h0, 32'h0, 1, 1'b0,
              NOT_FOUND_RESULT);
      add_row(iortt_pkg::OP_LOOKUP, 32'h0, 32'h5000, 32'h0, 32'h0, 1, 1'b0,
              NOT_FOUND_RESULT);
      // overlapping regions: lowest slot wins, remove uncovers the next
      add_row(iortt_pkg::OP_INSERT, 32'h1080, 32'h9000, 32'h7, 32'h1000, 1, 1'b1,
              '{status: iortt_pkg::ST_OK, slot: 5'd3, default: '0});
      add_row(iortt_pkg::OP_TRANSLATE, 32'h1080, 32'h0, 32'h0, 32'h0, 1, 1'b0,
              NOT_FOUND_RESULT);
      add_row(iortt_pkg::OP_REMOVE, 32'h1080, 32'h0, 32'h0, 32'h0, 1, 1'b0,
              NOT_FOUND_RESULT);
      add_row(iortt_pkg::OP_TRANSLATE, 32'h1080, 32'h0, 32'h0, 32'h0, 1, 1'b0,
              NOT_FOUND_RESULT);
      add_row(iortt_pkg::OP_INSERT, 32'h0, 32'h0, 32'h8000_0000, 32'h1, 1, 1'b1,
              '{status: iortt_pkg::ST_OK, slot: 5'd0, default: '0});
      // fill the rest, then one insert too many
      add_row(iortt_pkg::OP_INSERT, 32'h4000, 32'h7777, 32'h9, 32'h40, 16, 1'b0,
              NOT_FOUND_RESULT);
      add_row(iortt_pkg::OP_INSERT, 32'h0, 32'h0, 32'ha, 32'h10, 1, 1'b1, FULL_RESULT);
      add_row(iortt_pkg::OP_LOOKUP, 32'h0, 32'hffff_ffff, 32'h0, 32'h0, 1, 1'b0,
              NOT_FOUND_RESULT);
      add_row(iortt_pkg::OP_TRANSLATE, 32'h0, 32'h0, 32'h0, 32'h0, 1, 1'b0,
              NOT_FOUND_RESULT);
      add_row(iortt_pkg::OP_LOOKUP, 32'h0, 32'h7777, 32'h0, 32'h0, 1, 1'b0,
              NOT_FOUND_RESULT);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (stim_rows[r]) begin
         repeat (stim_rows[r].reps) begin
            offer_request(stim_rows[r].op, stim_rows[r].phys, stim_rows[r].virt,
                          stim_rows[r].handle, stim_rows[r].len);
            predicted = apply_region_op(stim_rows[r].op, stim_rows[r].phys, stim_rows[r].virt,
                                        stim_rows[r].handle, stim_rows[r].len);
            pending_results.push_back(stim_rows[r].typed ? stim_rows[r].want : predicted);
         end
      end

      // alternate grow and shrink phases; every fourth phase runs flat out
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         phase       = i / PHASE_LEN;
         quiet_phase = (phase % 4 == 3);
         draw_request(phase % 2 == 0, op, pa, vb, hd, len);
         offer_request(op, pa, vb, hd, len);
         pending_results.push_back(apply_region_op(op, pa, vb, hd, len));
      end
      req_valid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      // catch any stray result after the last expected one
      repeat (SLOTS + 8) @(posedge clock);
      if (mismatches == 0) begin
         $display("io_region_translation_table_core: match");
      end else begin
         $display("io_region_translation_table_core: mismatch");
      end
      $finish;
   end

   // receiver side: a random stall per item while the result waits
   initial begin : rsp_side
      int unsigned hold;
      int unsigned taken;
      taken     = 0;
      rsp_stall <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         hold = quiet_phase ? 0 : $urandom_range(0, 3);
         if (taken == HOLD_AT) begin
            // long hold-off while the sender keeps offering
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (hold != 0) begin
            rsp_stall <= 1'b1;
            do @(posedge clock); while (!rsp_valid);
            repeat (hold - 1) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
         taken++;
      end
   end

   // compare each taken result with the oldest pending expectation
   always @(posedge clock) begin : rsp_check
      region_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $display("%0t: result with no item pending, expected none actual status %0d",
                     $time, rsp_status);
            mismatches++;
         end else begin
            want = pending_results.pop_front();
            compare_field("status", 32'(want.status), 32'(rsp_status));
            compare_field("translated_address", want.trans_addr, rsp_translated_address);
            compare_field("phys_base_out", want.phys_base, rsp_phys_base_out);
            compare_field("size_out", want.region_len, rsp_size_out);
            compare_field("handle_out", want.handle, rsp_handle_out);
            compare_field("slot_index", 32'(want.slot), 32'(rsp_slot_index));
         end
      end
   end

   // watchdog, well beyond the slowest correct run
   initial begin : watchdog
      #5_000_000;
      $display("io_region_translation_table_core: mismatch");
      $finish;
   end

endmodule
